// ===== sv/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg: shared types and codes for the DDA line rasterizer
// Command codes, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  // Command codes carried on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } dda_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture endpoints, set up accumulators and divider
    logic div_step;  // one restoring-division iteration on both axes
    logic step;      // step transfer accepted: emit point if any remain
  } dda_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic k_zero;    // endpoints on the input give a zero step count
    logic div_last;  // current divider iteration is the final one
    logic out_stall; // output register full and not being taken
  } dda_status_t;

endpackage

// ===== sv/dda_ctrl.sv =====
// ----------------------------------------------------------------------------
// dda_ctrl: controller for the DDA line rasterizer
// Accepts input transfers while idle and sequences the per-line division.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_cmd_i,
  output logic                 s_tready_o,
  input  dda_pkg::dda_status_t status_i,
  output dda_pkg::dda_cmd_t    cmd_o
);
  import dda_pkg::*;

  dda_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = !status_i.out_stall;
        if (s_tvalid_i && s_tready_o) begin
          if (s_cmd_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
            if (!status_i.k_zero) begin
              state_d = ST_DIV;
            end
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dda_dp.sv =====
// ----------------------------------------------------------------------------
// dda_dp: datapath for the DDA line rasterizer
// Step count, radix-2 restoring divider for both increments, position
// accumulators with rounding, and the output register.
// ----------------------------------------------------------------------------
module dda_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dda_pkg::dda_cmd_t     cmd_i,
  output dda_pkg::dda_status_t  status_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_point_o
);
  import dda_pkg::*;

  localparam int ACC_W = COORD_BITS + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int REM_W = COORD_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [ACC_W-1:0]      acc_x_q, acc_y_q;
  logic [INC_W-1:0]      inc_x_q, inc_y_q;
  logic [COORD_BITS-1:0] remaining_q;
  logic [COORD_BITS-1:0] k_q;
  logic [REM_W-1:0]      rem_x_q, rem_y_q;
  logic [Q_W-1:0]        q_x_q, q_y_q;
  logic                  neg_x_q, neg_y_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_last_q;

  // Step count from the endpoints on the input
  logic [COORD_BITS-1:0] adx, ady, k_in;
  assign adx  = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign ady  = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
  assign k_in = (adx >= ady) ? adx : ady;

  // One restoring-division iteration per axis
  logic             ge_x, ge_y;
  logic [REM_W-1:0] rsub_x, rsub_y;
  logic [Q_W-1:0]   qn_x, qn_y;
  assign ge_x   = rem_x_q >= {1'b0, k_q};
  assign ge_y   = rem_y_q >= {1'b0, k_q};
  assign rsub_x = ge_x ? rem_x_q - {1'b0, k_q} : rem_x_q;
  assign rsub_y = ge_y ? rem_y_q - {1'b0, k_q} : rem_y_q;
  assign qn_x   = {q_x_q[Q_W-2:0], ge_x};
  assign qn_y   = {q_y_q[Q_W-2:0], ge_y};

  // Signed increments from the final quotients
  logic [INC_W-1:0] qe_x, qe_y;
  assign qe_x = INC_W'(qn_x);
  assign qe_y = INC_W'(qn_y);

  // Sign-extended increments and rounded positions
  logic [ACC_W-1:0] sinc_x, sinc_y, rnd_x, rnd_y;
  assign sinc_x = {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
  assign sinc_y = {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
  assign rnd_x  = acc_x_q + HALF;
  assign rnd_y  = acc_y_q + HALF;

  logic emit;
  assign emit = cmd_i.step && (remaining_q != '0);

  // Control registers: remaining count, divider count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        remaining_q <= k_in;
        cnt_q       <= CNT_W'(FRAC_BITS);
      end else begin
        if (emit) begin
          remaining_q <= remaining_q - 1'b1;
        end
        if (cmd_i.div_step) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: accumulators, increments, divider and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_x_q <= {start_x_i, {FRAC_BITS{1'b0}}};
      acc_y_q <= {start_y_i, {FRAC_BITS{1'b0}}};
      inc_x_q <= '0;
      inc_y_q <= '0;
      k_q     <= k_in;
      rem_x_q <= {1'b0, adx};
      rem_y_q <= {1'b0, ady};
      neg_x_q <= end_x_i < start_x_i;
      neg_y_q <= end_y_i < start_y_i;
      q_x_q   <= '0;
      q_y_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_x_q <= {rsub_x[REM_W-2:0], 1'b0};
      rem_y_q <= {rsub_y[REM_W-2:0], 1'b0};
      q_x_q   <= qn_x;
      q_y_q   <= qn_y;
      if (cnt_q == '0) begin
        inc_x_q <= neg_x_q ? (~qe_x + 1'b1) : qe_x;
        inc_y_q <= neg_y_q ? (~qe_y + 1'b1) : qe_y;
      end
    end else if (emit) begin
      acc_x_q <= acc_x_q + sinc_x;
      acc_y_q <= acc_y_q + sinc_y;
    end
    if (emit) begin
      out_x_q    <= rnd_x[ACC_W-1:FRAC_BITS];
      out_y_q    <= rnd_y[ACC_W-1:FRAC_BITS];
      out_last_q <= remaining_q == COORD_BITS'(1);
    end
  end

  // Status to the controller
  assign status_o.k_zero    = k_in == '0;
  assign status_o.div_last  = cnt_q == '0;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign last_point_o = out_last_q;

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line generator, top level
//
//   Channel  Dir  Beat contents
//   s_axis   in   tuser = cmd (0 load, 1 step); tdata = endpoints
//   m_axis   out  tdata = rounded point; tlast = final point of the line
//
// A step transfer's point is in the output register on the next cycle.
// A load of a zero-length line returns straight to idle; any other load
// runs the one-bit-per-cycle restoring divider for both increments and
// takes no input until it is done. Reset leaves no line loaded. Input is
// held off while the output register is full and not being taken.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: start_x, start_y, end_x, end_y (from bit 0 up), zero-padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: cmd
  input  logic s_axis_tuser_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata: pixel_x, pixel_y (from bit 0 up), zero-padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // tlast: last_point
  output logic m_axis_tlast_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i
);
  import dda_pkg::*;

  localparam int OUT_TW = ((2*COORD_BITS+7)/8)*8;

  dda_cmd_t              cmd;
  dda_status_t           status;
  logic [COORD_BITS-1:0] pixel_x, pixel_y;

  dda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_cmd_i    (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (s_axis_tdata_i[COORD_BITS-1:0]),
    .start_y_i    (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i      (s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i      (s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .last_point_o (m_axis_tlast_o)
  );

  // Pack the output point
  assign m_axis_tdata_o = OUT_TW'({pixel_y, pixel_x});

endmodule

// ===== tb/dda_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb: self-checking testbench for the DDA line rasterizer
// A short table of directed lines is followed by randomized line loads and
// step requests in three flow-control phases. An in-bench model of the line
// accumulators predicts every point not typed in a directed row, and each
// output transfer is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int COORD_W  = 12;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = COORD_W + FRAC_W;
  localparam int INC_W    = FRAC_W + 2;
  localparam int S_DATA_W = ((4*COORD_W+7)/8)*8;
  localparam int M_DATA_W = ((2*COORD_W+7)/8)*8;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int WD_LIMIT  = 2000;
  localparam int TAIL_CYC  = 2*INC_W + 4;
  localparam int PHASE_ITEMS = 284;
  localparam int TX_IDLE [3] = '{34, 60, 0};
  localparam int RX_IDLE [3] = '{60, 34, 0};

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   last;
    coord_t y;
    coord_t x;
  } point_t;

  // directed row: typed point is used only when chk is CHK_TYPED
  typedef enum logic {
    CHK_MODEL,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    chk_e   chk;
    logic   cmd;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    point_t pt;
  } dir_row_t;

  localparam int N_DIR = 24;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // step before any line: nothing drawn
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    // full diagonal, corner to corner
    '{CHK_MODEL, CMD_LOAD, 12'd0,    12'd0,    12'd4095, 12'd4095, '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd1,    12'd1}},
    // zero-length line at the far corner
    '{CHK_MODEL, CMD_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095, '{1'b0, 12'd0,    12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    // anti-diagonal, x falling
    '{CHK_MODEL, CMD_LOAD, 12'd4095, 12'd0,    12'd0,    12'd4095, '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd4095}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd1,    12'd4094}},
    // three-point horizontal run, end point excluded
    '{CHK_MODEL, CMD_LOAD, 12'd10,   12'd20,   12'd13,   12'd20,   '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd20,   12'd10}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd20,   12'd11}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b1, 12'd20,   12'd12}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    // step carries all-ones coordinates, which must be ignored
    '{CHK_MODEL, CMD_LOAD, 12'd100,  12'd100,  12'd103,  12'd101,  '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095, '{1'b0, 12'd100,  12'd100}},
    // reload while the previous line is still in progress
    '{CHK_MODEL, CMD_LOAD, 12'd2000, 12'd3000, 12'd1990, 12'd2993, '{1'b0, 12'd0,    12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    // steep line, y falling the full range
    '{CHK_MODEL, CMD_LOAD, 12'd0,    12'd4095, 12'd1,    12'd0,    '{1'b0, 12'd0,    12'd0}},
    '{CHK_TYPED, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd4095, 12'd0}},
    '{CHK_MODEL, CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    '{1'b0, 12'd0,    12'd0}}
  };

  // DUT signals
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = CMD_LOAD;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  // line model state
  logic [ACC_W-1:0]   pos_x, pos_y;
  logic [INC_W-1:0]   slope_x, slope_y;
  logic [COORD_W-1:0] pts_left;

  point_t pending_pts [$];
  int     err_cnt   = 0;
  int     n_loads   = 0;
  int     n_steps   = 0;
  int     n_points  = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     quiet_cyc = 0;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // delta * 2^FRAC / k, truncated toward zero, as a two's complement pattern
  function automatic logic [INC_W-1:0] slope_frac(input coord_t a, input coord_t b,
                                                  input coord_t k);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (b >= a) ? 64'(b) - 64'(a) : 64'(a) - 64'(b);
    q   = (mag << FRAC_W) / 64'(k);
    if (b < a) q = -q;
    return q[INC_W-1:0];
  endfunction

  // add one half, keep the integer part
  function automatic coord_t round_pos(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] t;
    t = acc + (ACC_W'(1) << (FRAC_W - 1));
    return t[ACC_W-1:FRAC_W];
  endfunction

  // advance the line model by one input transfer
  function automatic void trace_line(input logic cmd, input logic [S_DATA_W-1:0] data,
                                     output logic has_pt, output point_t pt);
    coord_t sx, sy, ex, ey, adx, ady, k;
    sx = data[COORD_W-1:0];
    sy = data[2*COORD_W-1:COORD_W];
    ex = data[3*COORD_W-1:2*COORD_W];
    ey = data[4*COORD_W-1:3*COORD_W];
    has_pt = 1'b0;
    pt     = '0;
    if (cmd == CMD_LOAD) begin
      adx = (ex >= sx) ? ex - sx : sx - ex;
      ady = (ey >= sy) ? ey - sy : sy - ey;
      k   = (adx >= ady) ? adx : ady;
      pos_x    = {sx, {FRAC_W{1'b0}}};
      pos_y    = {sy, {FRAC_W{1'b0}}};
      slope_x  = (k == 0) ? '0 : slope_frac(sx, ex, k);
      slope_y  = (k == 0) ? '0 : slope_frac(sy, ey, k);
      pts_left = k;
    end else if (pts_left != 0) begin
      has_pt  = 1'b1;
      pt.x    = round_pos(pos_x);
      pt.y    = round_pos(pos_y);
      pt.last = (pts_left == 1);
      pos_x = pos_x + {{(ACC_W-INC_W){slope_x[INC_W-1]}}, slope_x};
      pos_y = pos_y + {{(ACC_W-INC_W){slope_y[INC_W-1]}}, slope_y};
      pts_left = pts_left - 1'b1;
    end
  endfunction

  // one input transfer with random leading gaps; queues the expected point
  task automatic send_item(input logic cmd, input logic [S_DATA_W-1:0] data,
                           input chk_e chk, input point_t typed_pt);
    logic   has_pt;
    point_t pred_pt;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    trace_line(cmd, data, has_pt, pred_pt);
    if (cmd == CMD_LOAD) n_loads++;
    else n_steps++;
    if (chk == CHK_TYPED) pending_pts.push_back(typed_pt);
    else if (has_pt) pending_pts.push_back(pred_pt);
  endtask

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // mostly whole short lines with random content, some cut short or overrun,
  // plus a share of raw random transfers
  task automatic run_lines(input int n_items);
    int     sent;
    int     dmax, nsteps, sel;
    coord_t sx, sy, ex, ey, adx, ady, k;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_item(logic'($urandom_range(1)),
                  S_DATA_W'({$urandom, $urandom}), CHK_MODEL, '0);
        sent++;
      end else begin
        sel  = $urandom_range(99);
        dmax = (sel < 85) ? 12 : (sel < 97) ? 60 : 300;
        sx = ($urandom_range(7) == 0) ? coord_t'($urandom_range(1) * COORD_MAX)
                                      : coord_t'($urandom_range(COORD_MAX));
        sy = ($urandom_range(7) == 0) ? coord_t'($urandom_range(1) * COORD_MAX)
                                      : coord_t'($urandom_range(COORD_MAX));
        ex = clamp_coord(int'(sx) + int'($urandom_range(2*dmax)) - dmax);
        ey = clamp_coord(int'(sy) + int'($urandom_range(2*dmax)) - dmax);
        send_item(CMD_LOAD, {ey, ex, sy, sx}, CHK_MODEL, '0);
        sent++;
        adx = (ex >= sx) ? ex - sx : sx - ex;
        ady = (ey >= sy) ? ey - sy : sy - ey;
        k   = (adx >= ady) ? adx : ady;
        sel = $urandom_range(99);
        if (sel < 10 && k > 0) nsteps = $urandom_range(int'(k) - 1);
        else if (sel < 25) nsteps = int'(k) + $urandom_range(3, 1);
        else nsteps = int'(k);
        repeat (nsteps) begin
          send_item(CMD_STEP, S_DATA_W'({$urandom, $urandom}), CHK_MODEL, '0);
          sent++;
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // output checker
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pts.size() == 0) begin
        $error("point (%0d,%0d) with no point expected",
               m_axis_tdata_o[COORD_W-1:0], m_axis_tdata_o[2*COORD_W-1:COORD_W]);
        err_cnt++;
      end else begin
        exp_pt = pending_pts.pop_front();
        n_points++;
        if (m_axis_tdata_o[COORD_W-1:0] !== exp_pt.x) begin
          $error("pixel_x: expected %0d, got %0d", exp_pt.x, m_axis_tdata_o[COORD_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[2*COORD_W-1:COORD_W] !== exp_pt.y) begin
          $error("pixel_y: expected %0d, got %0d", exp_pt.y,
                 m_axis_tdata_o[2*COORD_W-1:COORD_W]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== exp_pt.last) begin
          $error("last_point: expected %0d, got %0d", exp_pt.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // main sequence
  initial begin
    dir_row_t row;
    pos_x = '0;
    pos_y = '0;
    slope_x = '0;
    slope_y = '0;
    pts_left = '0;
    tx_idle_pct = TX_IDLE[0];
    rx_idle_pct = RX_IDLE[0];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      send_item(row.cmd, {row.ey, row.ex, row.sy, row.sx}, row.chk, row.pt);
    end
    s_axis_tvalid_i <= 1'b0;

    // each phase ends with the sender held until the output has drained
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = TX_IDLE[ph];
      rx_idle_pct = RX_IDLE[ph];
      run_lines(PHASE_ITEMS);
      while (pending_pts.size() != 0) @(posedge clk_i);
    end

    repeat (TAIL_CYC) @(posedge clk_i);
    $display("Covered %0d line loads and %0d step requests, %0d points checked,",
             n_loads, n_steps, n_points);
    $display("under sender-heavy, receiver-heavy and free-running flow control.");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
